// ===== rtl/tdgs_pkg.sv =====
// ----------------------------------------------------------------------------
// tdgs_pkg
// shared types and constants of the task dependence graph scheduler
// ----------------------------------------------------------------------------
package tdgs_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int MAX_WORKERS = 16;
    localparam int WORKER_LIM  = (MAX_WORKERS < 16) ? MAX_WORKERS : 16;

    localparam int SLOT_W   = 6;
    localparam int PAT_W    = 64;
    localparam int WORKER_W = 4;
    localparam int WCNT_W   = 5;

    typedef enum logic {
        KIND_ADD    = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        EV_ASSIGNED = 2'd0,
        EV_READY    = 2'd1,
        EV_NONE     = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_FREE_SLOT = 2'd2
    } t_status;

    typedef struct packed {
        t_kind               kind;
        logic [PAT_W-1:0]    dep_pattern;
        logic [SLOT_W-1:0]   finished_slot;
    } t_req;

    typedef struct packed {
        t_event              event_res;
        logic [SLOT_W-1:0]   slot;
        logic                dispatch;
        logic [WORKER_W-1:0] worker;
        t_status             status;
        logic                last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              add;
        logic              rm_chk;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_row;
        logic              flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rm_ok;
    } t_sts;

endpackage

// ===== rtl/tdgs_ram.sv =====
// ----------------------------------------------------------------------------
// tdgs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tdgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tdgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdgs_ctrl
// request sequencer: add, remove check, row sweep, flush of the held result
// ----------------------------------------------------------------------------
module tdgs_ctrl #(
    parameter int SLOTS = tdgs_pkg::SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tdgs_pkg::t_kind i_kind,
    input  tdgs_pkg::t_sts i_sts,
    output tdgs_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import tdgs_pkg::*;

    localparam int ROW_W = $clog2(SLOTS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_CHK   = 6'b000100,
        S_SWEEP = 6'b001000,
        S_DRAIN = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        o_cmd         = '0;
        o_cmd.rd_row  = SLOT_W'(r_row);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = (i_kind == KIND_ADD) ? S_ADD : S_CHK;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_IDLE;
            end
            S_CHK: begin
                o_cmd.rm_chk = 1'b1;
                n_row        = '0;
                n_state      = i_sts.rm_ok ? S_SWEEP : S_IDLE;
            end
            S_SWEEP: begin
                o_cmd.rd_en = 1'b1;
                n_row       = r_row + ROW_W'(1);
                if (r_row == LAST_ROW) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/tdgs_dp.sv =====
// ----------------------------------------------------------------------------
// tdgs_dp
// datapath: wait-row ram, free-slot stack, occupancy, round robin, results
// ----------------------------------------------------------------------------
module tdgs_dp #(
    parameter int SLOTS = tdgs_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdgs_pkg::t_req                i_req,
    input  logic                          i_cfg_we,
    input  logic [tdgs_pkg::WCNT_W-1:0]   i_cfg_wdata,
    input  tdgs_pkg::t_cmd                i_cmd,
    output tdgs_pkg::t_sts                o_sts,
    output logic                          o_res_strobe,
    output tdgs_pkg::t_res                o_res
);
    import tdgs_pkg::*;

    localparam int ROW_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    t_req              r_req;
    logic [SLOTS-1:0]  r_occ, n_occ;
    logic [CNT_W-1:0]  r_fc, n_fc;
    logic [CNT_W-1:0]  r_low, n_low;
    logic [WCNT_W-1:0] r_wcnt;
    logic [WORKER_W-1:0] r_nw, n_nw;
    logic              r_q_vld;
    logic [ROW_W-1:0]  r_q_row;
    logic              r_hold_vld, n_hold_vld;
    logic [ROW_W-1:0]  r_hold_slot, n_hold_slot;
    logic [WORKER_W-1:0] r_hold_wk, n_hold_wk;
    logic              r_res_vld, n_res_vld;
    t_res              r_res, n_res;

    logic [CNT_W-1:0]  stk_idx;
    logic [ROW_W-1:0]  stk_q;
    logic              stk_we;
    logic [ROW_W-1:0]  row_q;
    logic              row_we;
    logic [ROW_W-1:0]  row_waddr;
    logic [SLOTS-1:0]  row_wdata;

    logic [WCNT_W-1:0] n_eff;
    logic [WORKER_W-1:0] nw_adv;
    logic [ROW_W-1:0]  fs_idx;
    logic              fs_in_range;
    logic [SLOTS-1:0]  col_mask;
    logic [SLOTS-1:0]  add_row;
    logic [ROW_W-1:0]  add_slot;
    logic [SLOTS-1:0]  row_prev, row_now;
    logic              row_ready;
    logic [SLOTS-1:0]  wait_q;

    // free-slot stack, entries below the low mark are never written and stand for their own index
    assign stk_idx = r_fc - CNT_W'(1);
    assign stk_we  = i_cmd.rm_chk && o_sts.rm_ok;

    tdgs_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_fc[ROW_W-1:0]),
        .i_wdata (fs_idx),
        .i_raddr (stk_idx[ROW_W-1:0]),
        .o_rdata (stk_q)
    );

    tdgs_ram #(.WIDTH(SLOTS), .DEPTH(SLOTS)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (i_cmd.rd_row[ROW_W-1:0]),
        .o_rdata (wait_q)
    );

    // round robin step
    always_comb begin
        if (r_wcnt == '0) begin
            n_eff = WCNT_W'(1);
        end else if (r_wcnt > WCNT_W'(WORKER_LIM)) begin
            n_eff = WCNT_W'(WORKER_LIM);
        end else begin
            n_eff = r_wcnt;
        end
        nw_adv = (WCNT_W'(r_nw) + WCNT_W'(1) == n_eff) ? '0 : r_nw + WORKER_W'(1);
    end

    assign fs_idx      = r_req.finished_slot[ROW_W-1:0];
    assign fs_in_range = ((SLOT_W + 1)'(r_req.finished_slot) < (SLOT_W + 1)'(SLOTS));
    assign o_sts.rm_ok = fs_in_range && r_occ[fs_idx];
    assign col_mask    = {{(SLOTS - 1){1'b0}}, 1'b1} << fs_idx;

    assign add_row  = r_req.dep_pattern[SLOTS-1:0];
    assign add_slot = (stk_idx < r_low) ? stk_idx[ROW_W-1:0] : stk_q;

    // rows of free slots read as zero through occupancy, which stands in for their reset
    assign row_q     = r_q_row;
    assign row_prev  = r_occ[row_q] ? wait_q : '0;
    assign row_now   = row_prev & ~col_mask;
    assign row_ready = r_occ[row_q] && (|row_prev) && !(|row_now);

    always_comb begin
        row_we    = 1'b0;
        row_waddr = row_q;
        row_wdata = row_now;
        if (i_cmd.add && r_fc != '0) begin
            row_we    = 1'b1;
            row_waddr = add_slot;
            row_wdata = add_row;
        end else if (r_q_vld) begin
            row_we = 1'b1;
        end
    end

    always_comb begin
        n_occ       = r_occ;
        n_fc        = r_fc;
        n_low       = r_low;
        n_nw        = r_nw;
        n_hold_vld  = r_hold_vld;
        n_hold_slot = r_hold_slot;
        n_hold_wk   = r_hold_wk;
        n_res_vld   = 1'b0;
        n_res       = r_res;

        if (i_cmd.add) begin
            n_res_vld = 1'b1;
            if (r_fc == '0) begin
                n_res = '{EV_NONE, '0, 1'b0, '0, ST_NO_SLOT, 1'b1};
            end else begin
                n_fc           = stk_idx;
                n_occ[add_slot] = 1'b1;
                if (stk_idx < r_low) begin
                    n_low = stk_idx;
                end
                if (add_row == '0) begin
                    n_nw  = nw_adv;
                    n_res = '{EV_ASSIGNED, SLOT_W'(add_slot), 1'b1, nw_adv, ST_OK, 1'b1};
                end else begin
                    n_res = '{EV_ASSIGNED, SLOT_W'(add_slot), 1'b0, '0, ST_OK, 1'b1};
                end
            end
        end

        if (i_cmd.rm_chk) begin
            if (o_sts.rm_ok) begin
                n_occ[fs_idx] = 1'b0;
                n_fc          = r_fc + CNT_W'(1);
                n_hold_vld    = 1'b0;
            end else begin
                n_res_vld = 1'b1;
                n_res     = '{EV_NONE, r_req.finished_slot, 1'b0, '0, ST_FREE_SLOT, 1'b1};
            end
        end

        // a new ready slot releases the one held before it
        if (r_q_vld && row_ready) begin
            n_nw        = nw_adv;
            n_hold_vld  = 1'b1;
            n_hold_slot = row_q;
            n_hold_wk   = nw_adv;
            if (r_hold_vld) begin
                n_res_vld = 1'b1;
                n_res     = '{EV_READY, SLOT_W'(r_hold_slot), 1'b1, r_hold_wk, ST_OK, 1'b0};
            end
        end

        if (i_cmd.flush) begin
            n_res_vld = 1'b1;
            if (r_hold_vld) begin
                n_res = '{EV_READY, SLOT_W'(r_hold_slot), 1'b1, r_hold_wk, ST_OK, 1'b1};
            end else begin
                n_res = '{EV_NONE, r_req.finished_slot, 1'b0, '0, ST_OK, 1'b1};
            end
        end

        if (i_cfg_we) begin
            n_nw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_fc       <= CNT_W'(SLOTS);
            r_low      <= CNT_W'(SLOTS);
            r_wcnt     <= WCNT_W'(1);
            r_nw       <= '0;
            r_q_vld    <= 1'b0;
            r_hold_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_occ      <= n_occ;
            r_fc       <= n_fc;
            r_low      <= n_low;
            r_nw       <= n_nw;
            r_q_vld    <= i_cmd.rd_en;
            r_hold_vld <= n_hold_vld;
            r_res_vld  <= n_res_vld;
            if (i_cfg_we) begin
                r_wcnt <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        r_q_row     <= i_cmd.rd_row[ROW_W-1:0];
        r_hold_slot <= n_hold_slot;
        r_hold_wk   <= n_hold_wk;
        r_res       <= n_res;
    end

    assign o_res_strobe = r_res_vld;
    assign o_res        = r_res;

endmodule

// ===== rtl/task_dependence_graph_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// task_dependence_graph_scheduler_core
// bit-matrix task scheduler: slots from a lifo free stack, ready slots to
// round-robin workers
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  request   start, busy, i_req             taken when start and not busy
//  result    o_res_strobe, o_res            one cycle per result, no back-off
//  config    i_cfg_we, i_cfg_wdata          written when i_cfg_we is high
//
//  add: the result shows in the cycle busy drops, and the next request can
//    be taken in that same cycle
//  remove: busy through the check, the one-row-a-cycle sweep of the wait-row
//    ram, a drain and a flush; final result in the cycle busy drops; error
//    removes are busy for the check only
//  ready slots of a remove come out one per cycle at most, in ascending order
//  reset is synchronous; no clearing pass, occupancy marks which rows are live
//  the receiver cannot stall: each result is shown for exactly one cycle
//
module task_dependence_graph_scheduler_core #(
    parameter int SLOTS = tdgs_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tdgs_pkg::t_req              i_req,
    output logic                        o_res_strobe,
    output tdgs_pkg::t_res              o_res,
    input  logic                        i_cfg_we,
    input  logic [tdgs_pkg::WCNT_W-1:0] i_cfg_wdata
);
    import tdgs_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: one request at a time, sweep counter for removes
    tdgs_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_req.kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: wait-row matrix, free stack, worker round robin, result register
    tdgs_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

// ===== rtl/tdgs_checker.sv =====
// ----------------------------------------------------------------------------
// tdgs_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
module tdgs_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           o_res_strobe,
    input  tdgs_pkg::t_res o_res
);
    import tdgs_pkg::*;

    // an accepted request always raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // errors come alone and report nothing
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.status != ST_OK |-> o_res.last && o_res.event_res == EV_NONE)
        else $error("error result not single");

    // more results follow while busy
    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_res.last |-> busy)
        else $error("non-final result outside a request");

    // the final result arrives once the request is done
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.last |-> !busy)
        else $error("final result while still busy");

    // only a real slot is dispatched
    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.dispatch |-> o_res.status == ST_OK && o_res.event_res != EV_NONE)
        else $error("dispatch on a failed result");

endmodule

bind task_dependence_graph_scheduler_core tdgs_checker u_checker (.*);

// ===== dv/task_dependence_graph_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// task_dependence_graph_scheduler_core_tb
// self-checking bench for the bit-matrix task scheduler: requests are planned
// against a shadow of the slot stack, driven in random bursts, and every
// result is matched field by field against a cycle-free prediction of the
// wait rows, the free-slot stack and the round-robin worker pointer
// ----------------------------------------------------------------------------
module task_dependence_graph_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdgs_pkg::*;

    localparam int NSLOT       = SLOTS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int NPHASE      = 5;
    // pattern bits at or above the slot count are dropped on add
    localparam logic [PAT_W-1:0] PAT_KEEP =
        (NSLOT >= PAT_W) ? {PAT_W{1'b1}} : ((64'd1 << NSLOT) - 64'd1);

    // per phase: worker count written, request count, occupancy aimed at
    localparam int PHASE_WCOUNT [NPHASE] = '{31, 0, 16, 1, 5};
    localparam int PHASE_LEN    [NPHASE] = '{70, 100, 70, 100, 60};
    localparam int PHASE_TARGET [NPHASE] = '{40, 64, 8, 64, 2};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_req              i_req = '0;
    logic              o_res_strobe;
    t_res              o_res;
    logic              i_cfg_we = 1'b0;
    logic [WCNT_W-1:0] i_cfg_wdata = '0;

    task_dependence_graph_scheduler_core #(
        .SLOTS (NSLOT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // scheduler prediction: wait rows, live slots, lifo free stack, rr pointer
    // ------------------------------------------------------------------------
    logic [PAT_W-1:0]    row_wait [NSLOT];
    logic [NSLOT-1:0]    live_slots;
    logic [SLOT_W-1:0]   free_slots [NSLOT];
    int                  free_total;
    logic [WORKER_W-1:0] rr_worker;
    logic [WCNT_W-1:0]   worker_cfg;

    t_res                due_results [$];
    t_req                queued_requests [$];
    int                  n_errors = 0;

    function automatic t_res pack_result(t_event ev, logic [SLOT_W-1:0] s, logic disp,
                                         logic [WORKER_W-1:0] wk, t_status st,
                                         logic fin);
        t_res r;
        r.event_res = ev;
        r.slot      = s;
        r.dispatch  = disp;
        r.worker    = wk;
        r.status    = st;
        r.last      = fin;
        return r;
    endfunction

    // advance the round robin; a count of zero acts as one, large counts clamp
    function automatic logic [WORKER_W-1:0] next_worker_id();
        int n;
        n = worker_cfg;
        if (n == 0) n = 1;
        if (n > WORKER_LIM) n = WORKER_LIM;
        rr_worker = WORKER_W'((int'(rr_worker) + 1) % n);
        return rr_worker;
    endfunction

    // work out every result one accepted request causes, in order
    task automatic schedule_request(t_req r);
        logic [PAT_W-1:0]  pat;
        logic [PAT_W-1:0]  prev;
        logic [PAT_W-1:0]  clear_mask;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] fs;
        t_res              readied [$];
        if (r.kind == KIND_ADD) begin
            if (free_total == 0) begin
                // stack exhausted: error, state untouched
                due_results.insert(due_results.size(),
                                   pack_result(EV_NONE, '0, 1'b0, '0, ST_NO_SLOT, 1'b1));
            end else begin
                free_total--;
                s             = free_slots[free_total];
                pat           = r.dep_pattern & PAT_KEEP;
                row_wait[s]   = pat;
                live_slots[s] = 1'b1;
                if (pat == '0) begin
                    // no dependences: straight to a worker
                    due_results.insert(due_results.size(),
                                       pack_result(EV_ASSIGNED, s, 1'b1, next_worker_id(),
                                                   ST_OK, 1'b1));
                end else begin
                    due_results.insert(due_results.size(),
                                       pack_result(EV_ASSIGNED, s, 1'b0, '0, ST_OK, 1'b1));
                end
            end
        end else begin
            fs = r.finished_slot;
            if (int'(fs) >= NSLOT || !live_slots[fs]) begin
                // removing a slot that holds no task
                due_results.insert(due_results.size(),
                                   pack_result(EV_NONE, fs, 1'b0, '0, ST_FREE_SLOT, 1'b1));
            end else begin
                clear_mask             = ~(64'd1 << fs);
                live_slots[fs]         = 1'b0;
                free_slots[free_total] = fs;
                free_total++;
                row_wait[fs]           = '0;
                // ascending sweep; a row readies only if it just went to zero
                for (int i = 0; i < NSLOT; i++) begin
                    prev        = row_wait[i];
                    row_wait[i] = prev & clear_mask;
                    if (prev != '0 && row_wait[i] == '0 && live_slots[i]) begin
                        readied.insert(readied.size(),
                                       pack_result(EV_READY, SLOT_W'(i), 1'b1,
                                                   next_worker_id(), ST_OK, 1'b0));
                    end
                end
                if (readied.size() == 0) begin
                    due_results.insert(due_results.size(),
                                       pack_result(EV_NONE, fs, 1'b0, '0, ST_OK, 1'b1));
                end else begin
                    readied[readied.size()-1].last = 1'b1;
                    foreach (readied[k]) due_results.insert(due_results.size(), readied[k]);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of requests with random gaps, or none in steady phases
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;
    bit steady     = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                schedule_request(i_req);
            end
            // free to change the request when none is waiting or it was just taken
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (queued_requests.size() > 0) begin
                    i_req <= queued_requests.pop_front();
                    start <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        if (steady) begin
                            gap_left = 0;
                        end else if ($urandom_range(0, 3) == 0) begin
                            // long gap, lands anywhere in a remove sweep
                            gap_left = $urandom_range(1, NSLOT + 16);
                        end else begin
                            gap_left = $urandom_range(1, 4);
                        end
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each strobed result against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: slot %0d event %0d",
                       o_res.slot, o_res.event_res);
                n_errors++;
            end else begin
                want = due_results.pop_front();
                check_field("event_res", want.event_res, o_res.event_res);
                check_field("slot", want.slot, o_res.slot);
                check_field("dispatch", want.dispatch, o_res.dispatch);
                check_field("worker", want.worker, o_res.worker);
                check_field("status", want.status, o_res.status);
                check_field("last", want.last, o_res.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without a request taken or a result shown
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("task_dependence_graph_scheduler_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request planning: shadow of occupancy and stack, so that removes mostly
    // name live slots and dependences point at live tasks
    // ------------------------------------------------------------------------
    logic [NSLOT-1:0]  plan_live;
    logic [SLOT_W-1:0] plan_stack [NSLOT];
    int                plan_free;

    task automatic push_add(logic [PAT_W-1:0] pat);
        t_req r;
        r.kind          = KIND_ADD;
        r.dep_pattern   = pat;
        r.finished_slot = SLOT_W'($urandom);
        queued_requests.insert(queued_requests.size(), r);
        if (plan_free > 0) begin
            plan_free--;
            plan_live[plan_stack[plan_free]] = 1'b1;
        end
    endtask

    task automatic push_remove(logic [SLOT_W-1:0] s);
        t_req r;
        r.kind          = KIND_REMOVE;
        r.dep_pattern   = {$urandom, $urandom};
        r.finished_slot = s;
        queued_requests.insert(queued_requests.size(), r);
        if (int'(s) < NSLOT && plan_live[s]) begin
            plan_live[s]          = 1'b0;
            plan_stack[plan_free] = s;
            plan_free++;
        end
    endtask

    // a live slot from a random starting point, or any slot if none is live
    function automatic logic [SLOT_W-1:0] pick_live();
        int base;
        base = $urandom_range(0, NSLOT - 1);
        for (int k = 0; k < NSLOT; k++) begin
            if (plan_live[(base + k) % NSLOT]) return SLOT_W'((base + k) % NSLOT);
        end
        return SLOT_W'(base);
    endfunction

    // mostly well-formed traffic steering occupancy towards a target
    task automatic queue_random(int count, int target);
        int               occupied;
        logic [PAT_W-1:0] pat;
        for (int n = 0; n < count; n++) begin
            occupied = $countones(plan_live);
            if ($urandom_range(0, 9) == 0) begin
                // noise: arbitrary pattern, or a remove of any slot
                if ($urandom_range(0, 1) == 1) push_add({$urandom, $urandom});
                else push_remove(SLOT_W'($urandom_range(0, NSLOT - 1)));
            end else if (occupied == 0 ||
                         $urandom_range(0, 9) < ((occupied < target) ? 8 : 3)) begin
                pat = '0;
                if ($urandom_range(0, 9) >= 4) begin
                    repeat ($urandom_range(1, 3)) pat[pick_live()] = 1'b1;
                end
                push_add(pat);
            end else begin
                push_remove(pick_live());
            end
        end
    endtask

    // settle on the falling edge so the clocked blocks have all run
    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || start || due_results.size() != 0 || busy);
    endtask

    task automatic write_worker_count(logic [WCNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        // written at this edge: the pointer restarts too
        worker_cfg = value;
        rr_worker  = '0;
    endtask

    // ------------------------------------------------------------------------
    // sequence: reset, directed requests, then random phases
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            row_wait[i]   = '0;
            free_slots[i] = SLOT_W'(i);
            plan_stack[i] = SLOT_W'(i);
        end
        live_slots = '0;
        free_total = NSLOT;
        rr_worker  = '0;
        worker_cfg = WCNT_W'(1);
        plan_live  = '0;
        plan_free  = NSLOT;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, worker count at its reset value
        push_remove(6'd0);                      // lowest slot, none live
        push_remove(6'd63);                     // highest slot, none live
        push_add(64'd0);                        // slot 63, ready at once
        push_add(64'h8000_0000_0000_0000);      // slot 62 waits on 63
        push_add({PAT_W{1'b1}});                // slot 61 waits on all, itself too
        push_add(64'hC000_0000_0000_0000);      // slot 60 waits on 62 and 63
        push_add(64'd0);                        // slot 59, ready at once
        push_remove(6'd63);                     // readies 62
        push_remove(6'd62);                     // readies 60
        push_remove(6'd59);                     // readies nothing
        push_remove(6'd62);                     // already free
        push_add(64'd1 << 60);                  // slot 59 waits on 60
        push_add(64'd1 << 60);                  // slot 62 waits on 60
        push_add((64'd1 << 60) | (64'd1 << 61)); // slot 63 waits on 60 and 61
        push_remove(6'd60);                     // readies 59 and 62, ascending
        push_remove(6'd61);                     // readies 63
        push_add(64'h5555_5555_5555_5555);
        push_add(64'hAAAA_AAAA_AAAA_AAAA);
        push_remove(6'd0);                      // never taken
        wait_idle();

        // random phases, alternating bursty and steady traffic
        for (int p = 0; p < NPHASE; p++) begin
            write_worker_count(WCNT_W'(PHASE_WCOUNT[p]));
            steady = (p % 2 == 1);
            queue_random(PHASE_LEN[p], PHASE_TARGET[p]);
            wait_idle();
        end

        // catch any stray result after the last sweep
        repeat (NSLOT + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("task_dependence_graph_scheduler_core_tb OK");
        end else begin
            $display("task_dependence_graph_scheduler_core_tb NOT OK");
        end
        $finish;
    end

endmodule
